// ----- rtl/sft_pkg.sv -----
`timescale 1ns / 1ps

package sft_pkg;

  // Forward control carried from cell to cell alongside the payload.
  typedef struct packed {
    logic valid;
    logic tir;
  } sft_ctl_t;

  // Register indexes (byte address / register stride).
  localparam logic [1:0] REG_BASE_REFL = 2'd0;
  localparam logic [1:0] REG_RATIO_SQ  = 2'd1;
  localparam logic [1:0] REG_ORDER     = 2'd2;

  // index_order codes; any code other than outer/inner behaves as equal indices.
  localparam logic [1:0] ORDER_EQUAL = 2'd0;
  localparam logic [1:0] ORDER_OUTER = 2'd1;
  localparam logic [1:0] ORDER_INNER = 2'd2;
  localparam logic [1:0] ORDER_SPARE = 2'd3;

  // (1 - c)^5 is built as m followed by this many multiplies by m.
  localparam int POW_STEPS = 4;

endpackage

// ----- rtl/sft_sqrt_cell.sv -----
`timescale 1ns / 1ps

// One result bit of the digit-by-digit square root.
// rem holds v - q^2; bit BIT_POS is set when (q + 2^k)^2 still fits.
module sft_sqrt_cell
  import sft_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int BIT_POS   = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sft_ctl_t                 up_ctl,
  input  logic [FRAC_BITS:0]       up_q,
  input  logic [2*FRAC_BITS:0]     up_rem,
  output logic                     up_ready,
  output sft_ctl_t                 dn_ctl,
  output logic [FRAC_BITS:0]       dn_q,
  output logic [2*FRAC_BITS:0]     dn_rem,
  input  logic                     dn_ready
);

  localparam int QW = FRAC_BITS + 1;
  localparam int RW = 2 * FRAC_BITS + 1;
  localparam int TW = 2 * FRAC_BITS + 3;

  logic          valid_r;
  logic          tir_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [TW-1:0] trial;
  logic          take;

  always_comb begin
    trial   = (TW'(up_q) << (BIT_POS + 1)) + (TW'(1) << (2 * BIT_POS));
    take    = TW'(up_rem) >= trial;
    q_nxt   = take ? (up_q + (QW'(1) << BIT_POS)) : up_q;
    rem_nxt = take ? RW'(TW'(up_rem) - trial) : up_rem;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      tir_r <= up_ctl.tir;
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign dn_ctl.valid = valid_r;
  assign dn_ctl.tir   = tir_r;
  assign dn_q         = q_r;
  assign dn_rem       = rem_r;

endmodule

// ----- rtl/sft_pow_cell.sv -----
`timescale 1ns / 1ps

// One step of the power chain: p <- (p * m) >> FRAC_BITS, m passed along.
module sft_pow_cell
  import sft_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sft_ctl_t           up_ctl,
  input  logic [FRAC_BITS:0] up_p,
  input  logic [FRAC_BITS:0] up_m,
  output logic               up_ready,
  output sft_ctl_t           dn_ctl,
  output logic [FRAC_BITS:0] dn_p,
  output logic [FRAC_BITS:0] dn_m,
  input  logic               dn_ready
);

  localparam int QW = FRAC_BITS + 1;
  localparam int PW = 2 * QW;

  logic          valid_r;
  logic          tir_r;
  logic [QW-1:0] p_r, p_nxt;
  logic [QW-1:0] m_r;
  logic [PW-1:0] prod;

  always_comb begin
    prod  = PW'(up_p) * PW'(up_m);
    p_nxt = prod[2*FRAC_BITS:FRAC_BITS];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      tir_r <= up_ctl.tir;
      p_r   <= p_nxt;
      m_r   <= up_m;
    end
  end

  assign dn_ctl.valid = valid_r;
  assign dn_ctl.tir   = tir_r;
  assign dn_p         = p_r;
  assign dn_m         = m_r;

endmodule

// ----- rtl/schlick_fresnel_tir.sv -----
`timescale 1ns / 1ps

// Schlick Fresnel reflectance with total internal reflection.
// Input channel: in_valid / in_stall carry one signed Q1.F incident cosine
// per transaction. Result channel: out_valid / out_stall carry the Q1.F
// reflectance (saturated at one) and the total-internal-reflection flag;
// each input transaction yields exactly one result, in order.
// Configuration: APB-style port, always ready; register i at byte 4*i
// (8*i when FRAC_BITS > 28 widens the data path to 64 bits). Writes are
// expected only while the pipe is empty.
// Pipeline: FRAC_BITS + 10 register stages (26 at F = 16) between an
// accepted input transaction and its result: three setup stages,
// FRAC_BITS + 1 square-root cells, four power cells, one blend multiply
// and the output register.
// Throughput: one transaction per cycle; every stage is a register with
// its own valid bit, so a new cosine enters each cycle the pipe moves.
// Stall: out_stall holds the output register; the ready chain is
// combinational and empty stages keep filling, so in_stall rises only
// once every stage holds a transaction and out_stall is high.
// Reset: all valid bits clear; registers return to f0 = 0.04,
// ratio^2 = 2.25, inner index greater.
module schlick_fresnel_tir
  import sft_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  localparam int CFG_DW = (FRAC_BITS + 4 > 32) ? 64 : 32,
  localparam int CFG_AW = (CFG_DW == 64) ? 5 : 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [FRAC_BITS+1:0] in_cos_incident,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [FRAC_BITS:0]       out_refl,
  output logic                     out_total_internal,
  // configuration port
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int QW  = FRAC_BITS + 1;       // unsigned Q1.F
  localparam int SW  = FRAC_BITS + 2;       // signed Q1.F
  localparam int RAW = FRAC_BITS + 4;       // unsigned Q4.F
  localparam int RW  = 2 * FRAC_BITS + 1;   // square-root remainder
  localparam int SQ_CELLS = FRAC_BITS + 1;

  localparam logic [QW-1:0]  ONE        = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]  F0_RST     = QW'((64'd2621 << FRAC_BITS) >> 16);
  localparam logic [RAW-1:0] RATIO_RST  = RAW'((64'd9 << FRAC_BITS) >> 2);
  localparam logic [1:0]     ORDER_RST  = ORDER_INNER;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [QW-1:0]  base_refl_r;
  logic [RAW-1:0] ratio_sq_r;
  logic [1:0]     order_r;
  logic [1:0]     cfg_idx;
  logic           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:CFG_AW-2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_refl_r <= F0_RST;
      ratio_sq_r  <= RATIO_RST;
      order_r     <= ORDER_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BASE_REFL: base_refl_r <= cfg_pwdata[QW-1:0];
        REG_RATIO_SQ:  ratio_sq_r  <= cfg_pwdata[RAW-1:0];
        REG_ORDER:     order_r     <= cfg_pwdata[1:0];
        default: ;     // unmapped: ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE_REFL: cfg_prdata = CFG_DW'(base_refl_r);
      REG_RATIO_SQ:  cfg_prdata = CFG_DW'(ratio_sq_r);
      REG_ORDER:     cfg_prdata = CFG_DW'(order_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // Ready chain: a stage loads when it is empty or its successor moves.
  // ------------------------------------------------------------------
  logic rdy_s0, rdy_s1, rdy_s2, rdy_bl, rdy_out;
  logic [SQ_CELLS:0]  sq_rdy;
  logic [POW_STEPS:0] pw_rdy;

  // ------------------------------------------------------------------
  // S0: magnitude, clamp to one, denser-side decision
  // ------------------------------------------------------------------
  logic [SW-1:0] cos_u, mag;
  logic          cos_neg, cos_pos, dense_in;
  logic [QW-1:0] a_in;
  logic          s0_v_r, s0_dense_r;
  logic [QW-1:0] s0_a_r;

  always_comb begin
    cos_u    = in_cos_incident;
    cos_neg  = cos_u[SW-1];
    cos_pos  = !cos_neg && (cos_u != '0);
    mag      = cos_neg ? (~cos_u + SW'(1)) : cos_u;
    a_in     = (mag > SW'(ONE)) ? ONE : mag[QW-1:0];
    dense_in = (cos_pos && (order_r == ORDER_OUTER)) ||
               (cos_neg && (order_r == ORDER_INNER));
  end

  assign rdy_s0   = !s0_v_r || rdy_s1;
  assign in_stall = !rdy_s0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy_s0) begin
      s0_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s0) begin
      s0_a_r     <= a_in;
      s0_dense_r <= dense_in;
    end
  end

  // ------------------------------------------------------------------
  // S1: 1 - cos^2
  // ------------------------------------------------------------------
  logic [2*QW-1:0] c2_prod;
  logic [QW-1:0]   om_nxt;
  logic            s1_v_r, s1_dense_r;
  logic [QW-1:0]   s1_a_r, s1_om_r;

  always_comb begin
    c2_prod = (2*QW)'(s0_a_r) * (2*QW)'(s0_a_r);
    om_nxt  = ONE - c2_prod[2*FRAC_BITS:FRAC_BITS];
  end

  assign rdy_s1 = !s1_v_r || rdy_s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy_s1) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s1) begin
      s1_a_r     <= s0_a_r;
      s1_dense_r <= s0_dense_r;
      s1_om_r    <= om_nxt;
    end
  end

  // ------------------------------------------------------------------
  // S2: sin^2 of the refracted angle, TIR test, square-root seed.
  // Non-dense and TIR transactions seed q = a with a zero remainder, so the
  // root cells leave q untouched.
  // ------------------------------------------------------------------
  localparam int S2W = QW + RAW;
  logic [S2W-1:0]  s2_prod;
  logic [RAW:0]    s2_val;
  logic            tir_nxt, do_root;
  logic [QW-1:0]   rad;
  logic [QW-1:0]   q_seed;
  logic [RW-1:0]   rem_seed;
  logic            s2_v_r, s2_tir_r;
  logic [QW-1:0]   s2_q_r;
  logic [RW-1:0]   s2_rem_r;

  always_comb begin
    s2_prod  = S2W'(s1_om_r) * S2W'(ratio_sq_r);
    s2_val   = s2_prod[S2W-1:FRAC_BITS];
    tir_nxt  = s1_dense_r && (s2_val >= (RAW+1)'(ONE));
    do_root  = s1_dense_r && !tir_nxt;
    rad      = ONE - s2_val[QW-1:0];
    q_seed   = do_root ? '0 : s1_a_r;
    rem_seed = do_root ? (RW'(rad) << FRAC_BITS) : '0;
  end

  assign rdy_s2 = !s2_v_r || sq_rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy_s2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_s2) begin
      s2_tir_r <= tir_nxt;
      s2_q_r   <= q_seed;
      s2_rem_r <= rem_seed;
    end
  end

  // ------------------------------------------------------------------
  // Square-root chain: cell j decides root bit FRAC_BITS - j.
  // ------------------------------------------------------------------
  sft_ctl_t      sq_ctl [SQ_CELLS+1];
  logic [QW-1:0] sq_q   [SQ_CELLS+1];
  logic [RW-1:0] sq_rem [SQ_CELLS+1];

  assign sq_ctl[0] = '{valid: s2_v_r, tir: s2_tir_r};
  assign sq_q[0]   = s2_q_r;
  assign sq_rem[0] = s2_rem_r;

  for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
    sft_sqrt_cell #(
      .FRAC_BITS (FRAC_BITS),
      .BIT_POS   (FRAC_BITS - j)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (sq_ctl[j]),
      .up_q     (sq_q[j]),
      .up_rem   (sq_rem[j]),
      .up_ready (sq_rdy[j]),
      .dn_ctl   (sq_ctl[j+1]),
      .dn_q     (sq_q[j+1]),
      .dn_rem   (sq_rem[j+1]),
      .dn_ready (sq_rdy[j+1])
    );
  end

  assign sq_rdy[SQ_CELLS] = pw_rdy[0];

  // ------------------------------------------------------------------
  // Power chain: (1 - c)^5
  // ------------------------------------------------------------------
  sft_ctl_t      pw_ctl [POW_STEPS+1];
  logic [QW-1:0] pw_p   [POW_STEPS+1];
  logic [QW-1:0] pw_m   [POW_STEPS+1];

  assign pw_ctl[0] = sq_ctl[SQ_CELLS];
  assign pw_m[0]   = ONE - sq_q[SQ_CELLS];
  assign pw_p[0]   = pw_m[0];

  for (genvar j = 0; j < POW_STEPS; j++) begin : g_pow
    sft_pow_cell #(
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_ctl   (pw_ctl[j]),
      .up_p     (pw_p[j]),
      .up_m     (pw_m[j]),
      .up_ready (pw_rdy[j]),
      .dn_ctl   (pw_ctl[j+1]),
      .dn_p     (pw_p[j+1]),
      .dn_m     (pw_m[j+1]),
      .dn_ready (pw_rdy[j+1])
    );
  end

  assign pw_rdy[POW_STEPS] = rdy_bl;

  // ------------------------------------------------------------------
  // Blend multiply: (1 - f0) * p
  // ------------------------------------------------------------------
  logic [QW-1:0]   f0_sat;
  logic [2*QW-1:0] bl_prod;
  logic            bl_v_r, bl_tir_r;
  logic [QW-1:0]   bl_term_r;

  always_comb begin
    f0_sat  = (base_refl_r > ONE) ? ONE : base_refl_r;
    bl_prod = (2*QW)'(ONE - f0_sat) * (2*QW)'(pw_p[POW_STEPS]);
  end

  assign rdy_bl = !bl_v_r || rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_v_r <= 1'b0;
    end else if (rdy_bl) begin
      bl_v_r <= pw_ctl[POW_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_bl) begin
      bl_tir_r  <= pw_ctl[POW_STEPS].tir;
      bl_term_r <= bl_prod[2*FRAC_BITS:FRAC_BITS];
    end
  end

  // ------------------------------------------------------------------
  // Output register: f0 + term, saturated; TIR forces one.
  // ------------------------------------------------------------------
  logic [QW:0]   refl_sum;
  logic [QW-1:0] refl_nxt;
  logic          out_valid_r;
  logic [QW-1:0] out_refl_r;
  logic          out_tir_r;

  always_comb begin
    refl_sum = (QW+1)'(f0_sat) + (QW+1)'(bl_term_r);
    if (bl_tir_r || (refl_sum > (QW+1)'(ONE))) begin
      refl_nxt = ONE;
    end else begin
      refl_nxt = refl_sum[QW-1:0];
    end
  end

  assign rdy_out = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= bl_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_refl_r <= refl_nxt;
      out_tir_r  <= bl_tir_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_refl           = out_refl_r;
  assign out_total_internal = out_tir_r;

endmodule

// ----- tb/sv/schlick_fresnel_tir_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the Schlick Fresnel / TIR pipe.
// Flow: reset, a directed sweep at reset register values, then phases that
// each reprogram all three registers (while the pipe is drained) and push a
// batch of random cosines. Driver and monitor are clocked always blocks; the
// driver pulls from cos_pending, predicts each transaction when it is
// accepted and queues the prediction in refl_expected; the monitor pops and
// compares field by field.
module schlick_fresnel_tir_tb
  import sft_pkg::*;
();

  localparam int FRAC = 16;
  localparam bit [63:0] ONE = 64'd1 << FRAC;
  localparam int POWER = 5;                    // Schlick exponent
  localparam int PIPE_LATENCY = FRAC + 10;     // accept to result
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 125;
  // Address just past the register map; writes there must be dropped.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic [FRAC:0] reflectance;
    logic          total_internal;
  } fresnel_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [FRAC+1:0] in_cos_incident;
  logic                   out_valid;
  logic                   out_stall;
  logic [FRAC:0]          out_refl;
  logic                   out_total_internal;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [3:0]             cfg_paddr;
  logic [31:0]            cfg_pwdata;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  // Shadow copy of the register file, updated as each write completes.
  logic [FRAC:0]   shadow_f0;
  logic [FRAC+3:0] shadow_ratio_sq;
  logic [1:0]      shadow_order;

  logic signed [FRAC+1:0] cos_pending[$];
  fresnel_t               refl_expected[$];
  int                     mismatches;

  // Idle control: per transaction wait draws, with calm stretches of no idling.
  int tx_gap;
  int rx_hold;
  bit tx_calm;
  bit rx_calm;

  schlick_fresnel_tir dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cos_incident   (in_cos_incident),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_refl          (out_refl),
    .out_total_internal(out_total_internal),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Bit-by-bit floor square root; the argument never exceeds 2^(2*FRAC).
  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = 64'd0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Expected reflectance for one cosine under the shadow registers.
  function automatic fresnel_t fresnel_predict(logic signed [FRAC+1:0] cos_in);
    bit [FRAC+1:0] raw;
    bit [FRAC+1:0] neg_raw;
    bit [63:0]     mag;
    bit [63:0]     c2;
    bit [63:0]     s2;
    bit [63:0]     m;
    bit [63:0]     p;
    bit [63:0]     f0;
    bit [63:0]     r;
    bit            neg;
    bit            pos;
    bit            dense;
    fresnel_t      res;
    raw = cos_in;
    neg = raw[FRAC+1];
    pos = !neg && (raw != '0);
    // Magnitude of the most negative code wraps to itself; it still reads
    // as a large unsigned value and saturates below.
    neg_raw = ~raw + 1'b1;
    mag = neg ? 64'(neg_raw) : 64'(raw);
    if (mag > ONE) mag = ONE;

    dense = (pos && shadow_order == ORDER_OUTER) ||
            (neg && shadow_order == ORDER_INNER);
    if (dense) begin
      c2 = (mag * mag) >> FRAC;
      s2 = ((ONE - c2) * 64'(shadow_ratio_sq)) >> FRAC;
      if (s2 >= ONE) begin
        res.reflectance    = ONE[FRAC:0];
        res.total_internal = 1'b1;
        return res;
      end
      mag = int_sqrt((ONE - s2) << FRAC);
      if (mag > ONE) mag = ONE;
    end

    m = ONE - mag;
    p = m;
    for (int k = 1; k < POWER; k++) p = (p * m) >> FRAC;

    f0 = 64'(shadow_f0);
    if (f0 > ONE) f0 = ONE;
    r = f0 + (((ONE - f0) * p) >> FRAC);
    if (r > ONE) r = ONE;
    res.reflectance    = r[FRAC:0];
    res.total_internal = 1'b0;
    return res;
  endfunction

  function automatic int draw_wait(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  // Mostly in-range cosines of either sign; some near zero and near one,
  // and some anywhere in the 18-bit code space (beyond one saturates).
  function automatic logic signed [FRAC+1:0] draw_cosine();
    logic signed [FRAC+1:0] v;
    case ($urandom_range(0, 9))
      0: v = (FRAC+2)'($urandom_range(0, (1 << (FRAC + 2)) - 1));
      1: begin
        if ($urandom_range(0, 1) != 0) v = (FRAC+2)'($urandom_range(0, 64));
        else v = (FRAC+2)'($urandom_range(32'(ONE) - 64, 32'(ONE)));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: begin
        v = (FRAC+2)'($urandom_range(0, 32'(ONE)));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  // Driver: holds valid and payload steady while stalled, then waits a drawn
  // gap before presenting the next queued cosine.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        refl_expected.push_back(fresnel_predict(in_cos_incident));
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (cos_pending.size() != 0) begin
          in_valid        <= 1'b1;
          in_cos_incident <= cos_pending.pop_front();
          if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
          tx_gap = draw_wait(tx_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every accepted result against the oldest prediction, then
  // hold stall high for a drawn wait.
  always @(posedge clk) begin
    fresnel_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (refl_expected.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected: reflectance %0d tir %0b",
                   $time, out_refl, out_total_internal);
        end else begin
          want = refl_expected.pop_front();
          if (out_refl !== want.reflectance) begin
            mismatches++;
            $display("%0t: reflectance mismatch: expected %0d, actual %0d",
                     $time, want.reflectance, out_refl);
          end
          if (out_total_internal !== want.total_internal) begin
            mismatches++;
            $display("%0t: total_internal mismatch: expected %0b, actual %0b",
                     $time, want.total_internal, out_total_internal);
          end
        end
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        rx_hold = draw_wait(rx_calm);
      end
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // APB write: setup cycle, access cycle, done at the edge pready is seen.
  // Upper bits of pwdata beyond the register width carry junk at times.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value, input int width);
    logic [31:0] data;
    data = value;
    if ($urandom_range(0, 2) == 0) data = data | (32'($urandom) << width);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_BASE_REFL: shadow_f0       = data[FRAC:0];
      REG_RATIO_SQ:  shadow_ratio_sq = data[FRAC+3:0];
      REG_ORDER:     shadow_order    = data[1:0];
      default: ;  // outside the map: dropped
    endcase
  endtask

  // Sample at the falling edge so the driver's and monitor's updates at the
  // rising edge have settled.
  task automatic wait_drained();
    while (cos_pending.size() != 0 || in_valid || refl_expected.size() != 0)
      @(negedge clk);
  endtask

  // Corners: zero, +/- one LSB, +/- just under one, +/- one, codes past one
  // in both directions, and the critical angle for ratio^2 = 2.25.
  task automatic queue_directed();
    logic signed [FRAC+1:0] corners[12];
    corners = '{18'sd0, 18'sd1, -18'sd1, 18'sd65535, -18'sd65535, 18'sd65536,
                -18'sd65536, 18'sd131071, -18'sd131072, -18'sd48840, 18'sd48840,
                -18'sd50000};
    foreach (corners[i]) cos_pending.push_back(corners[i]);
  endtask

  // Per-phase register settings: fixed corners first, then random ones.
  // Corners cover f0 of zero, one and above one, ratio^2 of one, max and
  // below one, and every index_order code including the unused one.
  task automatic program_phase(input int ph);
    logic [31:0] f0;
    logic [31:0] ratio;
    logic [31:0] order;
    case (ph)
      0: begin f0 = 0;      ratio = 32'd65536;   order = 32'(ORDER_OUTER); end
      1: begin f0 = 65536;  ratio = 32'd1048575; order = 32'(ORDER_INNER); end
      2: begin f0 = 131071; ratio = 32'd0;       order = 32'(ORDER_SPARE); end
      3: begin f0 = 2621;   ratio = 32'd147456;  order = 32'(ORDER_EQUAL); end
      4: begin f0 = 26000;  ratio = 32'd40000;   order = 32'(ORDER_INNER); end
      default: begin
        f0    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071)
                                            : $urandom_range(0, 65536);
        ratio = $urandom_range(0, 1048575);
        order = $urandom_range(0, 3);
      end
    endcase
    reg_write(REG_BASE_REFL, f0, FRAC + 1);
    reg_write(REG_RATIO_SQ, ratio, FRAC + 4);
    reg_write(REG_ORDER, order, 2);
    // A write past the map must not disturb anything.
    reg_write(REG_UNMAPPED, $urandom, 32);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cos_incident = '0;
    out_stall       = 1'b0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    shadow_f0       = 17'd2621;
    shadow_ratio_sq = 20'd147456;
    shadow_order    = ORDER_INNER;
    mismatches      = 0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sweep at reset register values.
    queue_directed();
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      program_phase(ph);
      if (ph == 0) queue_directed();
      repeat (ITEMS_PER_PHASE) cos_pending.push_back(draw_cosine());
      wait_drained();
    end

    // Let the pipe run empty to catch any stray result.
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
